>>> rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and constants shared by the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = 6;
   localparam int SLOT_W     = 8;
   localparam int CAP_W      = 9;
   localparam int STAT_W     = 2;
   localparam int LIM_W      = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_RANGE     = 2'd2,
      STAT_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

endpackage

>>> rtl/core/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit slot allocator over an occupancy bitmap held in 64-bit words.
// ----------------------------------------------------------------------------
//  channel  ports                        handshake
//  request  req_type, req_slot_to_free   start high while busy low
//  result   rsp_slot_given, rsp_status,  rsp_valid strobe, one cycle
//           rsp_slots_in_use
//  config   csr_wr_data                  csr_wr_en
//
//  a free reads one bitmap word, then checks it and writes it back. an
//  allocate scans words in order (one memory read per cycle), at most the
//  words covering capacity. out-of-range frees and allocates with zero
//  capacity answer straight from idle, with no bitmap read. a new item may
//  be started in the strobe cycle. reset clears the bitmap through per-word
//  valid bits at once, with no clearing pass. no stalls.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int MAX_SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [SLOT_W-1:0] req_slot_to_free,
   output logic              rsp_valid,
   output logic [SLOT_W-1:0] rsp_slot_given,
   output logic [STAT_W-1:0] rsp_status,
   output logic [CAP_W-1:0]  rsp_slots_in_use,
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data
);

   localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CW = (AW + 1 > LIM_W) ? AW + 1 : LIM_W;
   localparam int SW = (AW + WORD_SHIFT > CAP_W) ? AW + WORD_SHIFT : CAP_W;

   state_type               state_ff, state_in;
   logic [AW-1:0]           word_ff, word_in;
   logic [LIM_W-1:0]        lim_ff, lim_in;
   logic                    op_ff, op_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CAP_W-1:0]        count_ff, count_in;
   logic [CAP_W-1:0]        cap_ff;
   logic [NUM_WORDS-1:0]    vld_ff;
   logic                    vld_rd_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]       rsp_given_ff, rsp_given_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [CAP_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                    accept;
   logic [CAP_W-1:0]        cap_eff;
   logic [LIM_W-1:0]        nwords;
   logic                    wr_en;
   logic [WORD_BITS-1:0]    wr_data;
   logic [WORD_BITS-1:0]    ram_q;
   logic [WORD_BITS-1:0]    word_q;
   logic [WORD_SHIFT-1:0]   free_bit;
   logic [WORD_SHIFT-1:0]   free_pos;
   logic [WORD_BITS-1:0]    bit_mask;
   logic [SW-1:0]           slot_full;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign cap_eff = (32'(cap_ff) > MAX_SLOTS) ? CAP_W'(MAX_SLOTS) : cap_ff;
   assign nwords  = LIM_W'((10'(cap_eff) + 10'd63) >> WORD_SHIFT);

   assign word_q = vld_rd_ff ? ram_q : '0;

   // lowest clear bit of the word just read
   always_comb begin
      free_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word_q[i]) begin
            free_bit = WORD_SHIFT'(i);
         end
      end
   end

   assign free_pos  = (op_ff == OP_ALLOC) ? free_bit : slot_ff[WORD_SHIFT-1:0];
   assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << free_pos;
   assign slot_full = SW'({word_ff, free_bit});

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (word_in),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      lim_in        = lim_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_given_in  = rsp_given_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_data       = word_q;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in        = req_type;
               slot_in      = req_slot_to_free;
               lim_in       = nwords;
               rsp_given_in = '0;
               rsp_count_in = count_ff;
               if (req_type == OP_ALLOC) begin
                  word_in = '0;
                  if (nwords == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_FULL;
                  end else begin
                     state_in = ST_EVAL;
                  end
               end else begin
                  word_in = AW'(req_slot_to_free >> WORD_SHIFT);
                  if (CAP_W'(req_slot_to_free) >= cap_eff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_RANGE;
                  end else begin
                     state_in = ST_EVAL;
                  end
               end
            end
         end
         ST_EVAL: begin
            rsp_given_in = '0;
            if (op_ff == OP_ALLOC) begin
               if (&word_q) begin
                  if ((CW'(word_ff) + CW'(1)) < CW'(lim_ff)) begin
                     word_in = word_ff + AW'(1);
                  end else begin
                     state_in      = ST_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_FULL;
                     rsp_count_in  = count_ff;
                  end
               end else begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  if (slot_full < SW'(cap_eff)) begin
                     wr_en         = 1'b1;
                     wr_data       = word_q | bit_mask;
                     count_in      = count_ff + CAP_W'(1);
                     rsp_given_in  = slot_full[SLOT_W-1:0];
                     rsp_status_in = STAT_OK;
                     rsp_count_in  = count_ff + CAP_W'(1);
                  end else begin
                     rsp_status_in = STAT_FULL;
                     rsp_count_in  = count_ff;
                  end
               end
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if ((word_q & bit_mask) == '0) begin
                  rsp_status_in = STAT_NOT_ALLOC;
                  rsp_count_in  = count_ff;
               end else begin
                  wr_en         = 1'b1;
                  wr_data       = word_q & ~bit_mask;
                  count_in      = count_ff - CAP_W'(1);
                  rsp_status_in = STAT_OK;
                  rsp_count_in  = count_ff - CAP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         vld_ff       <= '0;
         vld_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_rd_ff    <= vld_ff[word_in];
         if (wr_en) begin
            vld_ff[word_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      lim_ff        <= lim_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_given   = rsp_given_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slots_in_use = rsp_count_ff;

endmodule
